FILE: rtl/core/assert_macros.svh
// Assertion macros for the chunked decoder RTL; included by hcd_parser.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define AST_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/hcd_pkg.sv
// Shared types and codes for the HTTP chunked body decoder.
// No dependencies; imported by hcd_parser and http_chunked_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

  localparam int SIZE_W = 31;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       chunk_last;
    logic [1:0] status;
    logic [2:0] error_code;
  } out_item_t;

  localparam logic [1:0] ACT_DATA    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [3:0] PH_HDR_WS  = 4'd0;
  localparam logic [3:0] PH_HDR_HEX = 4'd1;
  localparam logic [3:0] PH_HDR_TWS = 4'd2;
  localparam logic [3:0] PH_HDR_LF  = 4'd3;
  localparam logic [3:0] PH_EXT     = 4'd4;
  localparam logic [3:0] PH_EXT_LF  = 4'd5;
  localparam logic [3:0] PH_BODY    = 4'd6;
  localparam logic [3:0] PH_BODY_CR = 4'd7;
  localparam logic [3:0] PH_BODY_LF = 4'd8;
  localparam logic [3:0] PH_LAST    = 4'd9;
  localparam logic [3:0] PH_LAST_LF = 4'd10;
  localparam logic [3:0] PH_TRAILER = 4'd11;
  localparam logic [3:0] PH_FINISH  = 4'd12;
  localparam logic [3:0] PH_ERROR   = 4'd13;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SYNTAX   = 3'd1;
  localparam logic [2:0] ERR_SIZE     = 3'd2;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd3;
  localparam logic [2:0] ERR_MISMATCH = 3'd4;

  localparam logic [1:0] STAT_BUSY   = 2'd0;
  localparam logic [1:0] STAT_DONE   = 2'd1;
  localparam logic [1:0] STAT_FAILED = 2'd2;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = {SIZE_W{1'b1}};

endpackage

`default_nettype wire

FILE: rtl/core/hcd_parser.sv
// Parser state and one-word step logic of the chunked decoder.
// Uses hcd_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hcd_parser (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  hcd_pkg::in_item_t             item,
  input  wire logic [hcd_pkg::SIZE_W-1:0] max_chunk_size,
  output hcd_pkg::out_item_t            result
);
  import hcd_pkg::*;

  logic [3:0]        phase, phase_next;
  logic [SIZE_W-1:0] size_remaining, size_remaining_next;
  logic              digit_seen, digit_seen_next;
  logic [1:0]        crlf_progress, crlf_progress_next;
  logic [2:0]        error_store, error_store_next;

  logic              is_hex;
  logic [3:0]        hex_nib;
  logic              is_blank;
  logic [SIZE_W+3:0] size_acc;
  logic [SIZE_W-1:0] size_dec;
  logic [7:0]        b;
  logic [7:0]        want;
  logic              pay_valid;
  logic              pay_last;

  assign b        = item.data_byte;
  assign is_blank = (b == CH_SP) || (b == CH_TAB);
  assign size_acc = {size_remaining, 4'd0} + {{SIZE_W{1'b0}}, hex_nib};
  assign size_dec = size_remaining - {{(SIZE_W-1){1'b0}}, 1'b1};
  assign want     = crlf_progress[0] ? CH_LF : CH_CR;

  always_comb begin
    is_hex  = 1'b1;
    hex_nib = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_nib = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      hex_nib = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    phase_next          = phase;
    size_remaining_next = size_remaining;
    digit_seen_next     = digit_seen;
    crlf_progress_next  = crlf_progress;
    error_store_next    = error_store;
    pay_valid           = 1'b0;
    pay_last            = 1'b0;
    priority case (item.action)
      ACT_RESTART: begin
        phase_next          = PH_HDR_WS;
        size_remaining_next = '0;
        digit_seen_next     = 1'b0;
        crlf_progress_next  = 2'd0;
        error_store_next    = ERR_NONE;
      end
      ACT_TIMEOUT: begin
        phase_next       = PH_ERROR;
        error_store_next = ERR_TIMEOUT;
      end
      ACT_DATA: begin
        unique case (phase)
          PH_HDR_WS, PH_HDR_HEX: begin
            if (is_hex) begin
              // size check before the value is kept, so it never wraps
              if (size_acc > {4'd0, max_chunk_size}) begin
                phase_next       = PH_ERROR;
                error_store_next = ERR_SIZE;
              end else begin
                size_remaining_next = size_acc[SIZE_W-1:0];
                digit_seen_next     = 1'b1;
                phase_next          = PH_HDR_HEX;
              end
            end else if (is_blank) begin
              if (phase == PH_HDR_HEX) phase_next = PH_HDR_TWS;
            end else if (digit_seen && b == CH_SEMI) begin
              phase_next = PH_EXT;
            end else if (digit_seen && b == CH_CR) begin
              phase_next = PH_HDR_LF;
            end else begin
              phase_next       = PH_ERROR;
              error_store_next = ERR_SYNTAX;
            end
          end
          PH_HDR_TWS: begin
            if (is_blank) begin
              phase_next = phase;
            end else if (b == CH_SEMI) begin
              phase_next = PH_EXT;
            end else if (b == CH_CR) begin
              phase_next = PH_HDR_LF;
            end else begin
              phase_next       = PH_ERROR;
              error_store_next = ERR_SYNTAX;
            end
          end
          PH_HDR_LF: begin
            if (b == CH_LF) begin
              phase_next = (size_remaining == '0) ? PH_LAST : PH_BODY;
            end else begin
              phase_next       = PH_ERROR;
              error_store_next = ERR_SYNTAX;
            end
          end
          PH_EXT: begin
            if (b == CH_CR) phase_next = PH_EXT_LF;
          end
          PH_EXT_LF: begin
            if (b == CH_LF) begin
              phase_next = (size_remaining == '0) ? PH_LAST : PH_BODY;
            end else if (b != CH_CR) begin
              phase_next = PH_EXT;
            end
          end
          PH_BODY: begin
            pay_valid           = 1'b1;
            size_remaining_next = size_dec;
            if (size_dec == '0) begin
              pay_last   = 1'b1;
              phase_next = PH_BODY_CR;
            end
          end
          PH_BODY_CR: begin
            if (b == CH_CR) begin
              phase_next = PH_BODY_LF;
            end else begin
              phase_next       = PH_ERROR;
              error_store_next = ERR_MISMATCH;
            end
          end
          PH_BODY_LF: begin
            if (b == CH_LF) begin
              phase_next          = PH_HDR_WS;
              size_remaining_next = '0;
              digit_seen_next     = 1'b0;
            end else begin
              phase_next       = PH_ERROR;
              error_store_next = ERR_MISMATCH;
            end
          end
          PH_LAST: begin
            if (b == CH_CR) begin
              phase_next = PH_LAST_LF;
            end else begin
              phase_next         = PH_TRAILER;
              crlf_progress_next = 2'd0;
            end
          end
          PH_LAST_LF: begin
            if (b == CH_LF) begin
              phase_next = PH_FINISH;
            end else begin
              phase_next         = PH_TRAILER;
              crlf_progress_next = (b == CH_CR) ? 2'd1 : 2'd0;
            end
          end
          PH_TRAILER: begin
            // match CR LF CR LF; a stray CR restarts the match at one
            if (b == want) begin
              if (crlf_progress == 2'd3) begin
                phase_next         = PH_FINISH;
                crlf_progress_next = 2'd0;
              end else begin
                crlf_progress_next = crlf_progress + 2'd1;
              end
            end else begin
              crlf_progress_next = (b == CH_CR) ? 2'd1 : 2'd0;
            end
          end
          PH_FINISH, PH_ERROR: begin
            phase_next = phase;
          end
          default: begin
            phase_next       = PH_ERROR;
            error_store_next = ERR_SYNTAX;
          end
        endcase
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    result.payload_valid = pay_valid;
    result.payload_byte  = pay_valid ? b : 8'd0;
    result.chunk_last    = pay_last;
    result.error_code    = error_store_next;
    if (phase_next == PH_ERROR) begin
      result.status = STAT_FAILED;
    end else if (phase_next == PH_FINISH) begin
      result.status = STAT_DONE;
    end else begin
      result.status = STAT_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR_WS;
      size_remaining <= '0;
      digit_seen     <= 1'b0;
      crlf_progress  <= 2'd0;
      error_store    <= ERR_NONE;
    end else if (advance) begin
      phase          <= phase_next;
      size_remaining <= size_remaining_next;
      digit_seen     <= digit_seen_next;
      crlf_progress  <= crlf_progress_next;
      error_store    <= error_store_next;
    end
  end

  `AST_HOLDS(a_error_has_code, (phase != PH_ERROR) || (error_store != ERR_NONE), "error phase without code")
  `AST_HOLDS(a_body_has_bytes, (phase != PH_BODY) || (size_remaining != '0), "body phase with zero bytes left")
  `AST_NEXT(a_error_sticky, advance && phase == PH_ERROR && item.action == ACT_DATA, phase == PH_ERROR && $stable(error_store), "error state left on data word")
  `AST_NEXT(a_restart_clears, advance && item.action == ACT_RESTART, phase == PH_HDR_WS && error_store == ERR_NONE && !digit_seen, "restart did not clear parser")

endmodule

`default_nettype wire

FILE: rtl/core/http_chunked_decoder_top.sv
// A word taken into the input register reaches the output register through the parser once
// the output slot is free. Throughput: one word per cycle unless out_stall holds the output.
// An input register and an output register sit around the parser, so input is taken
// while a result waits. Reset (rst, synchronous): parser cleared, no words held,
// max_chunk_size set to all ones. cfg_ready is always high.
// Top level of the chunked decoder: handshake registers around hcd_parser; uses hcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  hcd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output hcd_pkg::out_item_t              out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [hcd_pkg::SIZE_W-1:0] cfg_data
);
  import hcd_pkg::*;

  logic              in_q_valid;
  in_item_t          in_q;
  logic              advance;
  logic              take;
  out_item_t         step_result;
  logic [SIZE_W-1:0] max_chunk_size;

  // move the held word through the parser when the output slot frees up
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_size <= MAX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_chunk_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= in_data;
    end
  end

  hcd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .item           (in_q),
    .max_chunk_size (max_chunk_size),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for http_chunked_decoder_top: directed framing and error cases,
// then random chunked streams under several size limits, with random idle and stall.
// Depends on hcd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;
  import hcd_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SIZE_W-1:0]   cfg_data;

  http_chunked_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Decoder state as the bench sees it.
  logic [3:0]        dec_phase;
  logic [SIZE_W-1:0] dec_left;
  logic              dec_digit;
  logic [1:0]        dec_crlf;
  logic [2:0]        dec_err;
  logic [SIZE_W-1:0] limit_reg;

  out_item_t pending_results[$];
  in_item_t  msg_q[$];
  out_item_t want;
  int        items_sent;
  int        fail_count;
  bit        sender_idles;
  bit        receiver_stalls;
  int        stall_left;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void clear_decoder();
    dec_phase = PH_HDR_WS;
    dec_left  = '0;
    dec_digit = 1'b0;
    dec_crlf  = 2'd0;
    dec_err   = ERR_NONE;
  endfunction

  function automatic void fail_with(logic [2:0] code);
    dec_phase = PH_ERROR;
    dec_err   = code;
  endfunction

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  // Advance the decoder by one word and return the result it produces.
  function automatic out_item_t decode_word(in_item_t w);
    out_item_t   r;
    int          h;
    logic [35:0] acc;
    logic [7:0]  b;
    logic [7:0]  want_b;
    r = '0;
    b = w.data_byte;
    case (w.action)
      ACT_DATA: begin
        case (dec_phase)
          PH_HDR_WS, PH_HDR_HEX: begin
            h = hex_val(b);
            if (h >= 0) begin
              acc = {1'b0, dec_left, 4'h0} | {32'd0, h[3:0]};
              if (acc > {5'd0, limit_reg}) begin
                fail_with(ERR_SIZE);
              end else begin
                dec_left  = acc[SIZE_W-1:0];
                dec_digit = 1'b1;
                dec_phase = PH_HDR_HEX;
              end
            end else if (is_blank(b)) begin
              if (dec_phase == PH_HDR_HEX) dec_phase = PH_HDR_TWS;
            end else if (dec_digit && b == CH_SEMI) begin
              dec_phase = PH_EXT;
            end else if (dec_digit && b == CH_CR) begin
              dec_phase = PH_HDR_LF;
            end else begin
              fail_with(ERR_SYNTAX);
            end
          end
          PH_HDR_TWS: begin
            if (b == CH_SEMI) dec_phase = PH_EXT;
            else if (b == CH_CR) dec_phase = PH_HDR_LF;
            else if (!is_blank(b)) fail_with(ERR_SYNTAX);
          end
          PH_HDR_LF: begin
            if (b == CH_LF) dec_phase = (dec_left == 0) ? PH_LAST : PH_BODY;
            else fail_with(ERR_SYNTAX);
          end
          PH_EXT: begin
            if (b == CH_CR) dec_phase = PH_EXT_LF;
          end
          PH_EXT_LF: begin
            if (b == CH_LF) dec_phase = (dec_left == 0) ? PH_LAST : PH_BODY;
            else if (b != CH_CR) dec_phase = PH_EXT;
          end
          PH_BODY: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            dec_left = dec_left - 1'b1;
            if (dec_left == 0) begin
              r.chunk_last = 1'b1;
              dec_phase    = PH_BODY_CR;
            end
          end
          PH_BODY_CR: begin
            if (b == CH_CR) dec_phase = PH_BODY_LF;
            else fail_with(ERR_MISMATCH);
          end
          PH_BODY_LF: begin
            if (b == CH_LF) begin
              dec_phase = PH_HDR_WS;
              dec_left  = '0;
              dec_digit = 1'b0;
            end else begin
              fail_with(ERR_MISMATCH);
            end
          end
          PH_LAST: begin
            if (b == CH_CR) begin
              dec_phase = PH_LAST_LF;
            end else begin
              dec_phase = PH_TRAILER;
              dec_crlf  = 2'd0;
            end
          end
          PH_LAST_LF: begin
            if (b == CH_LF) begin
              dec_phase = PH_FINISH;
            end else begin
              dec_phase = PH_TRAILER;
              dec_crlf  = (b == CH_CR) ? 2'd1 : 2'd0;
            end
          end
          PH_TRAILER: begin
            // match CR LF CR LF; a stray CR restarts the match at one
            want_b = dec_crlf[0] ? CH_LF : CH_CR;
            if (b == want_b) begin
              if (dec_crlf == 2'd3) begin
                dec_phase = PH_FINISH;
                dec_crlf  = 2'd0;
              end else begin
                dec_crlf = dec_crlf + 2'd1;
              end
            end else begin
              dec_crlf = (b == CH_CR) ? 2'd1 : 2'd0;
            end
          end
          PH_FINISH, PH_ERROR: ;
          default: fail_with(ERR_SYNTAX);
        endcase
      end
      ACT_RESTART: clear_decoder();
      ACT_TIMEOUT: fail_with(ERR_TIMEOUT);
      default: ;
    endcase
    if (dec_phase == PH_ERROR) r.status = STAT_FAILED;
    else if (dec_phase == PH_FINISH) r.status = STAT_DONE;
    else r.status = STAT_BUSY;
    r.error_code = dec_err;
    return r;
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver side: random stall bursts, toggled on and off in long stretches.
  initial begin
    out_stall       = 1'b0;
    receiver_stalls = 1'b1;
    stall_left      = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) receiver_stalls = !receiver_stalls;
      if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall  = 1'b0;
        stall_left = pick_gap(receiver_stalls);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result word %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.payload_valid !== want.payload_valid ||
            out_data.payload_byte  !== want.payload_byte  ||
            out_data.chunk_last    !== want.chunk_last    ||
            out_data.status        !== want.status        ||
            out_data.error_code    !== want.error_code) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch pv/byte/last/status/err exp %b/%h/%b/%0d/%0d got %b/%h/%b/%0d/%0d",
                     $time, want.payload_valid, want.payload_byte, want.chunk_last,
                     want.status, want.error_code, out_data.payload_valid,
                     out_data.payload_byte, out_data.chunk_last, out_data.status,
                     out_data.error_code);
        end
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_word(input logic [1:0] act, input logic [7:0] b);
    int gap;
    gap = pick_gap(sender_idles);
    repeat (gap) @(negedge clk);
    in_data.action    = act;
    in_data.data_byte = b;
    in_valid          = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(decode_word(in_data));
    items_sent = items_sent + 1;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(ACT_DATA, s[i]);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [SIZE_W-1:0] value);
    drain_results();
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void push_word(logic [1:0] act, logic [7:0] b);
    in_item_t w;
    w.action    = act;
    w.data_byte = b;
    msg_q.push_back(w);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return "0" + n;
    return (upper ? "A" : "a") + n - 10;
  endfunction

  function automatic void add_header(int size);
    int  nd;
    int  k;
    bit  upper;
    logic [7:0] b;
    upper = $urandom_range(0, 1);
    repeat ($urandom_range(0, 2)) push_word(ACT_DATA, $urandom_range(0, 1) ? CH_SP : CH_TAB);
    repeat ($urandom_range(0, 3) == 0) push_word(ACT_DATA, "0");
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    for (k = nd - 1; k >= 0; k--) push_word(ACT_DATA, hex_char(size >> (4 * k), upper));
    repeat ($urandom_range(0, 3) == 0) push_word(ACT_DATA, CH_SP);
    if ($urandom_range(0, 9) < 3) begin
      push_word(ACT_DATA, CH_SEMI);
      repeat ($urandom_range(0, 5)) begin
        b = $urandom_range(0, 255);
        if (b == CH_CR) b = CH_SEMI;
        push_word(ACT_DATA, b);
      end
      // a lone CR inside the extension must not end it
      if ($urandom_range(0, 4) == 0) begin
        push_word(ACT_DATA, CH_CR);
        push_word(ACT_DATA, "q");
      end
    end
    push_word(ACT_DATA, CH_CR);
    push_word(ACT_DATA, CH_LF);
  endfunction

  function automatic void build_message();
    int i;
    int r;
    int size;
    msg_q.delete();
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 99);
      size = (r < 70) ? $urandom_range(1, 8) :
             (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 80);
      add_header(size);
      repeat (size) push_word(ACT_DATA, $urandom_range(0, 255));
      push_word(ACT_DATA, CH_CR);
      push_word(ACT_DATA, CH_LF);
    end
    add_header(0);
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 9);
          push_word(ACT_DATA, (r == 0) ? ":" : (r == 1) ? " " : $urandom_range("a", "z"));
        end
        push_word(ACT_DATA, CH_CR);
        push_word(ACT_DATA, CH_LF);
      end
    end
    push_word(ACT_DATA, CH_CR);
    push_word(ACT_DATA, CH_LF);
    // corrupt a share of the messages
    r = $urandom_range(0, 99);
    i = $urandom_range(0, msg_q.size() - 1);
    if (r < 8) begin
      msg_q[i].data_byte = $urandom_range(0, 255);
    end else if (r < 12) begin
      msg_q.insert(i, '{action: ACT_TIMEOUT, data_byte: $urandom_range(0, 255)});
    end else if (r < 15) begin
      msg_q.insert(i, '{action: ACT_UNUSED, data_byte: $urandom_range(0, 255)});
    end else if (r < 18) begin
      while (msg_q.size() > i) void'(msg_q.pop_back());
    end
    repeat ($urandom_range(0, 2)) push_word(ACT_DATA, $urandom_range(0, 255));
    push_word(ACT_RESTART, $urandom_range(0, 255));
  endfunction

  // Long size fields that probe the limit check near the top of the range.
  function automatic void build_big_header();
    msg_q.delete();
    push_word(ACT_DATA, $urandom_range(0, 1) ? "7" : hex_char($urandom_range(0, 15), 1'b1));
    repeat ($urandom_range(6, 8)) push_word(ACT_DATA, $urandom_range(0, 3) ? "f" : "F");
    push_word(ACT_DATA, CH_CR);
    push_word(ACT_DATA, CH_LF);
    repeat ($urandom_range(1, 4)) push_word(ACT_DATA, $urandom_range(0, 255));
    push_word(ACT_RESTART, 8'h00);
  endfunction

  task automatic send_message();
    int i;
    sender_idles = ($urandom_range(0, 3) != 0);
    for (i = 0; i < msg_q.size(); i++) send_word(msg_q[i].action, msg_q[i].data_byte);
  endtask

  task automatic test_chunk_walk();
    send_text(" 2\t;x\015\n");
    send_word(ACT_DATA, 8'h00);
    send_word(ACT_DATA, 8'hFF);
    // zero size with an extension, then a bare CRLF finishes
    send_text("\015\n0;\015\n\015\n");
    send_word(ACT_DATA, 8'h55);
    send_word(ACT_UNUSED, 8'hAA);
    send_word(ACT_TIMEOUT, 8'h00);
    send_word(ACT_RESTART, 8'hFF);
  endtask

  task automatic test_header_errors();
    send_text(";");
    send_word(ACT_RESTART, 8'h00);
    send_text("1\015x");
    send_word(ACT_RESTART, 8'h00);
    send_text("1 2");
    send_word(ACT_RESTART, 8'h00);
    send_text("1\015\nAB");
    send_word(ACT_RESTART, 8'h00);
  endtask

  task automatic test_size_limit();
    write_limit('0);
    send_text("1");
    send_word(ACT_RESTART, 8'h00);
    send_text("0\015\nT\015\n\015\n");
    send_word(ACT_RESTART, 8'h00);
    write_limit(31'd15);
    send_text("FF");
    send_word(ACT_RESTART, 8'h00);
  endtask

  task automatic test_random_streams();
    logic [SIZE_W-1:0] limits[5];
    int                budget[5];
    int                p;
    int                target;
    bit                paused;
    limits = '{MAX_SIZE_RESET, 31'h28, 31'd8, 31'd0, 31'($urandom)};
    budget = '{500, 400, 250, 100, 250};
    for (p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      target = items_sent + budget[p];
      paused = 1'b0;
      while (items_sent < target) begin
        if ($urandom_range(0, 19) == 0) build_big_header();
        else build_message();
        send_message();
        if (!paused && items_sent > target - budget[p] / 2) begin
          // hold off until the decoder has answered everything
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    items_sent   = 0;
    fail_count   = 0;
    sender_idles = 1'b1;
    limit_reg    = MAX_SIZE_RESET;
    clear_decoder();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_chunk_walk();
    test_header_errors();
    test_size_limit();
    test_random_streams();
    write_limit(MAX_SIZE_RESET);

    drain_results();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
